FILE: sv/fixed_point_q16_alu_core_assert.svh
// ----------------------------------------------------------------------------
// fixed_point_q16_alu_core assertion macros
// shared assertion forms for the q16 alu checker
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_Q16_ALU_CORE_ASSERT_SVH
`define FIXED_POINT_Q16_ALU_CORE_ASSERT_SVH

// checked outside of reset
`define FPQ16_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fpq16 assertion failed");

// checked on every edge, reset included
`define FPQ16_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("fpq16 reset assertion failed");

`endif

FILE: sv/fpq16_pkg.sv
// ----------------------------------------------------------------------------
// fpq16_pkg
// types and codes shared by the q16.16 fixed-point alu modules
// ----------------------------------------------------------------------------
package fpq16_pkg;

   localparam int unsigned OPND_W = 32;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   // per-item control traveling down the divider chain
   typedef struct packed {
      logic              valid;
      logic              is_div;
      logic              neg;
      logic [OPND_W-1:0] result;
      status_type        status;
   } ctl_type;

endpackage

FILE: sv/fpq16_front.sv
// ----------------------------------------------------------------------------
// fpq16_front
// operand stage: multiply, add/subtract, and divider setup
// ----------------------------------------------------------------------------
module fpq16_front #(
   parameter  int unsigned FRAC_BITS = 16,
   localparam int unsigned DVD_W     = fpq16_pkg::OPND_W + FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             enable,
   input  logic                             in_valid,
   input  logic [1:0]                       in_cmd,
   input  logic signed [fpq16_pkg::OPND_W-1:0] in_a,
   input  logic signed [fpq16_pkg::OPND_W-1:0] in_b,
   output fpq16_pkg::ctl_type               dst_ctl,
   output logic [fpq16_pkg::OPND_W-1:0]     dst_rem,
   output logic [DVD_W-1:0]                 dst_dvd,
   output logic [fpq16_pkg::OPND_W-1:0]     dst_dsr
);
   import fpq16_pkg::*;

   localparam logic [2*OPND_W-1:0] MulBias = (64'd1 << FRAC_BITS) - 64'd1;

   logic                      s0_valid_ff;
   cmd_type                   cmd_s0_ff;
   logic signed [OPND_W-1:0]  a_s0_ff;
   logic signed [OPND_W-1:0]  b_s0_ff;
   logic signed [2*OPND_W-1:0] prod_s0_ff;
   logic signed [2*OPND_W-1:0] prod_s0_in;

   logic [OPND_W:0]           sum;
   logic [OPND_W:0]           diff;
   logic [2*OPND_W-1:0]       prod_adj;
   logic signed [2*OPND_W-1:0] prod_q;
   logic                      mul_fits;
   logic [OPND_W-1:0]         a_mag;
   logic [OPND_W-1:0]         b_mag;

   ctl_type                   ctl_ff;
   ctl_type                   ctl_in;
   logic [OPND_W-1:0]         rem_ff;
   logic [OPND_W-1:0]         rem_in;
   logic [DVD_W-1:0]          dvd_ff;
   logic [DVD_W-1:0]          dvd_in;
   logic [OPND_W-1:0]         dsr_ff;
   logic [OPND_W-1:0]         dsr_in;

   assign prod_s0_in = in_a * in_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (enable) begin
         s0_valid_ff <= in_valid;
      end
      if (enable) begin
         cmd_s0_ff  <= cmd_type'(in_cmd);
         a_s0_ff    <= in_a;
         b_s0_ff    <= in_b;
         prod_s0_ff <= prod_s0_in;
      end
   end

   assign sum  = {a_s0_ff[OPND_W-1], a_s0_ff} + {b_s0_ff[OPND_W-1], b_s0_ff};
   assign diff = {a_s0_ff[OPND_W-1], a_s0_ff} - {b_s0_ff[OPND_W-1], b_s0_ff};

   // truncate toward zero: bias negative products before the shift
   assign prod_adj = prod_s0_ff[2*OPND_W-1] ? (prod_s0_ff + MulBias) : prod_s0_ff;
   assign prod_q   = $signed(prod_adj) >>> FRAC_BITS;
   assign mul_fits = (&prod_q[2*OPND_W-1:OPND_W-1]) | ~(|prod_q[2*OPND_W-1:OPND_W-1]);

   assign a_mag = a_s0_ff[OPND_W-1] ? (~a_s0_ff + 32'd1) : a_s0_ff;
   assign b_mag = b_s0_ff[OPND_W-1] ? (~b_s0_ff + 32'd1) : b_s0_ff;

   always_comb begin
      ctl_in        = '0;
      ctl_in.valid  = s0_valid_ff;
      ctl_in.status = ST_OK;
      rem_in        = '0;
      dvd_in        = {a_mag, {FRAC_BITS{1'b0}}};
      dsr_in        = b_mag;
      case (cmd_s0_ff)
         CMD_ADD: begin
            ctl_in.result = sum[OPND_W-1:0];
            ctl_in.status = (sum[OPND_W] == sum[OPND_W-1]) ? ST_OK : ST_OVERFLOW;
         end
         CMD_SUB: begin
            ctl_in.result = diff[OPND_W-1:0];
            ctl_in.status = (diff[OPND_W] == diff[OPND_W-1]) ? ST_OK : ST_OVERFLOW;
         end
         CMD_MUL: begin
            ctl_in.result = prod_q[OPND_W-1:0];
            ctl_in.status = mul_fits ? ST_OK : ST_OVERFLOW;
         end
         CMD_DIV: begin
            if (b_s0_ff == '0) begin
               ctl_in.status = ST_DIV_ZERO;
            end else begin
               ctl_in.is_div = 1'b1;
               ctl_in.neg    = a_s0_ff[OPND_W-1] ^ b_s0_ff[OPND_W-1];
            end
         end
         default: begin
            ctl_in.status = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (enable) begin
         ctl_ff <= ctl_in;
      end
      if (enable) begin
         rem_ff <= rem_in;
         dvd_ff <= dvd_in;
         dsr_ff <= dsr_in;
      end
   end

   assign dst_ctl = ctl_ff;
   assign dst_rem = rem_ff;
   assign dst_dvd = dvd_ff;
   assign dst_dsr = dsr_ff;

endmodule

FILE: sv/fpq16_div_cell.sv
// ----------------------------------------------------------------------------
// fpq16_div_cell
// one restoring divide step: shifts in one dividend bit, emits one quotient bit
// ----------------------------------------------------------------------------
module fpq16_div_cell #(
   parameter int unsigned DVD_W = 48
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  fpq16_pkg::ctl_type           src_ctl,
   input  logic [fpq16_pkg::OPND_W-1:0] src_rem,
   input  logic [DVD_W-1:0]             src_dvd,
   input  logic [fpq16_pkg::OPND_W-1:0] src_dsr,
   output fpq16_pkg::ctl_type           dst_ctl,
   output logic [fpq16_pkg::OPND_W-1:0] dst_rem,
   output logic [DVD_W-1:0]             dst_dvd,
   output logic [fpq16_pkg::OPND_W-1:0] dst_dsr
);
   import fpq16_pkg::*;

   logic [OPND_W:0]   trial;
   logic [OPND_W:0]   trial_sub;
   logic              take;

   ctl_type           ctl_ff;
   logic [OPND_W-1:0] rem_ff;
   logic [OPND_W-1:0] rem_in;
   logic [DVD_W-1:0]  dvd_ff;
   logic [DVD_W-1:0]  dvd_in;
   logic [OPND_W-1:0] dsr_ff;

   assign trial     = {src_rem, src_dvd[DVD_W-1]};
   assign trial_sub = trial - {1'b0, src_dsr};
   assign take      = ~trial_sub[OPND_W];
   assign rem_in    = take ? trial_sub[OPND_W-1:0] : trial[OPND_W-1:0];
   assign dvd_in    = {src_dvd[DVD_W-2:0], take};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (enable) begin
         ctl_ff <= src_ctl;
      end
      if (enable) begin
         rem_ff <= rem_in;
         dvd_ff <= dvd_in;
         dsr_ff <= src_dsr;
      end
   end

   assign dst_ctl = ctl_ff;
   assign dst_rem = rem_ff;
   assign dst_dvd = dvd_ff;
   assign dst_dsr = dsr_ff;

endmodule

FILE: sv/fpq16_back.sv
// ----------------------------------------------------------------------------
// fpq16_back
// quotient sign and range check, result select, output register with skid
// ----------------------------------------------------------------------------
module fpq16_back #(
   parameter int unsigned DVD_W = 48
) (
   input  logic                         clock,
   input  logic                         reset,
   output logic                         enable,
   input  fpq16_pkg::ctl_type           src_ctl,
   input  logic [DVD_W-1:0]             src_dvd,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [fpq16_pkg::OPND_W-1:0] out_result,
   output logic [1:0]                   out_status
);
   import fpq16_pkg::*;

   logic [OPND_W-1:0] q_low;
   logic [OPND_W-1:0] div_res;
   logic              fits_pos;
   logic              fits_neg;
   logic              div_fits;
   logic              fin_valid;
   logic [OPND_W-1:0] fin_result;
   status_type        fin_status;

   logic              out_valid_ff;
   logic              out_valid_in;
   logic [OPND_W-1:0] out_res_ff;
   logic [OPND_W-1:0] out_res_in;
   status_type        out_st_ff;
   status_type        out_st_in;
   logic              skid_valid_ff;
   logic              skid_valid_in;
   logic [OPND_W-1:0] skid_res_ff;
   logic [OPND_W-1:0] skid_res_in;
   status_type        skid_st_ff;
   status_type        skid_st_in;

   assign enable = ~skid_valid_ff;

   assign q_low    = src_dvd[OPND_W-1:0];
   assign fits_pos = ~(|src_dvd[DVD_W-1:OPND_W-1]);
   assign fits_neg = ~(|src_dvd[DVD_W-1:OPND_W]) &
                     (~src_dvd[OPND_W-1] | ~(|src_dvd[OPND_W-2:0]));
   assign div_res  = src_ctl.neg ? (~q_low + 32'd1) : q_low;
   assign div_fits = src_ctl.neg ? fits_neg : fits_pos;

   assign fin_valid  = src_ctl.valid & enable;
   assign fin_result = src_ctl.is_div ? div_res : src_ctl.result;
   assign fin_status = src_ctl.is_div ? (div_fits ? ST_OK : ST_OVERFLOW) : src_ctl.status;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_res_in    = out_res_ff;
      out_st_in     = out_st_ff;
      skid_valid_in = skid_valid_ff;
      skid_res_in   = skid_res_ff;
      skid_st_in    = skid_st_ff;
      if (out_valid_ff && out_ready) begin
         if (skid_valid_ff) begin
            out_res_in    = skid_res_ff;
            out_st_in     = skid_st_ff;
            skid_valid_in = 1'b0;
         end else if (fin_valid) begin
            out_res_in = fin_result;
            out_st_in  = fin_status;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (out_valid_ff) begin
         if (fin_valid) begin
            skid_valid_in = 1'b1;
            skid_res_in   = fin_result;
            skid_st_in    = fin_status;
         end
      end else if (fin_valid) begin
         out_valid_in = 1'b1;
         out_res_in   = fin_result;
         out_st_in    = fin_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_res_ff  <= out_res_in;
      out_st_ff   <= out_st_in;
      skid_res_ff <= skid_res_in;
      skid_st_ff  <= skid_st_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_res_ff;
   assign out_status = out_st_ff;

endmodule

FILE: sv/fixed_point_q16_alu_core.sv
// ----------------------------------------------------------------------------
// fixed_point_q16_alu_core
// signed q16.16 add, subtract, multiply and divide with status
//
//   channel  | direction | tdata                     | tuser
//   req_     | in        | operand_a, operand_b      | command
//   rsp_     | out       | result_value              | status_code
//
// one item per cycle while the skid register is empty; each item passes through the
// operand stage, the row of one-bit divide cells and the output register
// every command runs through the whole cell row so results stay in order
// reset clears the valid bits, plus the whole per-item control word of the front and cells
// a result arriving behind a stalled one moves into the skid register; req_tready drops only
// while that skid register is full, freezing the whole row
// ----------------------------------------------------------------------------
module fixed_point_q16_alu_core #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // operand_a [31:0], operand_b [63:32]
   input  logic [1:0]  req_tuser,   // command [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // result_value [31:0]
   output logic [1:0]  rsp_tuser    // status_code [1:0]
);
   import fpq16_pkg::*;

   localparam int unsigned DVD_W = OPND_W + FRAC_BITS;

   logic              enable;
   ctl_type           ctl_chain [DVD_W+1];
   logic [OPND_W-1:0] rem_chain [DVD_W+1];
   logic [DVD_W-1:0]  dvd_chain [DVD_W+1];
   logic [OPND_W-1:0] dsr_chain [DVD_W+1];

   assign req_tready = enable;

   fpq16_front #(
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .enable  (enable),
      .in_valid(req_tvalid),
      .in_cmd  (req_tuser),
      .in_a    (req_tdata[31:0]),
      .in_b    (req_tdata[63:32]),
      .dst_ctl (ctl_chain[0]),
      .dst_rem (rem_chain[0]),
      .dst_dvd (dvd_chain[0]),
      .dst_dsr (dsr_chain[0])
   );

   for (genvar i = 0; i < DVD_W; i++) begin : g_cell
      fpq16_div_cell #(
         .DVD_W(DVD_W)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .enable (enable),
         .src_ctl(ctl_chain[i]),
         .src_rem(rem_chain[i]),
         .src_dvd(dvd_chain[i]),
         .src_dsr(dsr_chain[i]),
         .dst_ctl(ctl_chain[i+1]),
         .dst_rem(rem_chain[i+1]),
         .dst_dvd(dvd_chain[i+1]),
         .dst_dsr(dsr_chain[i+1])
      );
   end

   fpq16_back #(
      .DVD_W(DVD_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .src_ctl   (ctl_chain[DVD_W]),
      .src_dvd   (dvd_chain[DVD_W]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_result(rsp_tdata),
      .out_status(rsp_tuser)
   );

endmodule

FILE: sv/fpq16_checker.sv
// ----------------------------------------------------------------------------
// fpq16_checker
// port-level checks for the q16.16 alu core
// ----------------------------------------------------------------------------
`include "fixed_point_q16_alu_core_assert.svh"

module fpq16_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import fpq16_pkg::*;

   // stalled result holds
   `FPQ16_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // divide by zero returns zero
   `FPQ16_ASSERT(a_div_zero_value, clock, reset, rsp_tvalid && rsp_tuser == ST_DIV_ZERO |-> rsp_tdata == 32'd0)

   // an empty output stage never back-pressures the input
   `FPQ16_ASSERT(a_ready_when_empty, clock, reset, !rsp_tvalid |-> req_tready)

   // reset leaves the block empty and ready
   `FPQ16_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid && req_tready)

endmodule

bind fixed_point_q16_alu_core fpq16_checker u_fpq16_checker (.*);

FILE: sim/tb_fixed_point_q16_alu_core.sv
// ----------------------------------------------------------------------------
// tb_fixed_point_q16_alu_core
// self-checking bench for the signed q16.16 alu: a directed set of edge
// operands, then random operations under several idle and stall mixes and
// one long output hold-off; every result is checked against an in-bench
// fixed-point predictor in transfer order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fixed_point_q16_alu_core;
   import fpq16_pkg::*;

   localparam int unsigned FRAC_BITS    = 16;
   localparam int          CLK_PERIOD   = 20;
   localparam int          DRAIN_CYCLES = 32 + FRAC_BITS + 3 + 20;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam longint      Q_SCALE      = longint'(1) << FRAC_BITS;
   localparam longint      INT32_LO     = -64'sd2147483648;
   localparam longint      INT32_HI     = 64'sd2147483647;
   localparam logic [31:0] Q_MAX        = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN        = 32'h8000_0000;
   localparam logic [31:0] Q_ONE        = 32'h0001_0000;

   typedef struct packed {
      logic [31:0] value;
      status_type  status;
   } alu_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // operand_a [31:0], operand_b [63:32]
   logic [1:0]  req_tuser  = CMD_ADD;   // command [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // result_value [31:0]
   logic [1:0]  rsp_tuser;          // status_code [1:0]

   alu_result_type pending_results[$];
   alu_result_type oldest_result;
   int          error_count       = 0;
   int          cycle_count       = 0;
   int          send_idle_pct     = 0;
   int          sink_stall_pct    = 0;
   int          sink_hold_cycles  = 0;

   fixed_point_q16_alu_core #(
      .FRAC_BITS (FRAC_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_fixed_point_q16_alu_core NOT OK");
         $finish;
      end
   end

   // fixed-point arithmetic with c-style truncating division
   function automatic alu_result_type predict_alu(cmd_type cmd, logic [31:0] a_raw,
                                                  logic [31:0] b_raw);
      longint         a;
      longint         b;
      longint         exact;
      alu_result_type r;
      a        = longint'($signed(a_raw));
      b        = longint'($signed(b_raw));
      exact    = 0;
      r.status = ST_OK;
      case (cmd)
         CMD_ADD: exact = a + b;
         CMD_SUB: exact = a - b;
         CMD_MUL: exact = (a * b) / Q_SCALE;
         default: begin
            if (b == 0) begin
               r.value  = '0;
               r.status = ST_DIV_ZERO;
               return r;
            end
            exact = (a * Q_SCALE) / b;
         end
      endcase
      if (exact < INT32_LO || exact > INT32_HI)
         r.status = ST_OVERFLOW;
      r.value = exact[31:0];
      return r;
   endfunction

   function automatic logic [31:0] rand_operand();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(7))
         0: v = $urandom_range(32'h3_FFFF);
         1: v = -$urandom_range(32'h3_FFFF);
         2: v = ($urandom_range(400) - 200) << FRAC_BITS;
         3: begin
            case ($urandom_range(6))
               0: v = Q_MAX;
               1: v = Q_MIN;
               2: v = '0;
               3: v = 32'h0000_0001;
               4: v = 32'hFFFF_FFFF;
               5: v = Q_ONE;
               default: v = -Q_ONE;
            endcase
         end
         default: ;
      endcase
      return v;
   endfunction

   // output side: long hold-off first, then random stalls
   always @(negedge clock) begin
      if (sink_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         sink_hold_cycles = sink_hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transfer: result_value %h status_code %0d",
                   rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_tdata !== oldest_result.value) begin
               $error("result_value expected %h got %h", oldest_result.value, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== oldest_result.status) begin
               $error("status_code expected %0d got %0d", oldest_result.status, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   // called and returns at a falling edge; valid stays up for the next item
   task automatic send_op(input cmd_type cmd, input logic [31:0] a, input logic [31:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_alu(cmd, a, b));
      @(negedge clock);
   endtask

   task automatic set_pace(input int idle_pct, input int stall_pct, input int hold);
      req_tvalid <= 1'b0;
      @(posedge clock);
      send_idle_pct    = idle_pct;
      sink_stall_pct   = stall_pct;
      sink_hold_cycles = hold;
      @(negedge clock);
   endtask

   task automatic test_edge_operands();
      set_pace(0, 0, 0);
      send_op(CMD_ADD, Q_MAX, 32'h0000_0001);
      send_op(CMD_ADD, Q_MIN, Q_MIN);
      send_op(CMD_ADD, 32'h0001_8000, 32'hFFFF_4000);
      send_op(CMD_SUB, Q_MIN, 32'h0000_0001);
      send_op(CMD_SUB, 32'h0000_0000, Q_MIN);
      send_op(CMD_SUB, Q_MAX, Q_MAX);
      send_op(CMD_MUL, Q_ONE, Q_ONE);
      send_op(CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
      send_op(CMD_MUL, 32'hFFFF_8000, 32'h0001_8000);
      send_op(CMD_MUL, Q_MIN, Q_MIN);
      send_op(CMD_MUL, Q_MAX, Q_MAX);
      send_op(CMD_MUL, Q_MIN, Q_ONE);
      send_op(CMD_MUL, Q_MAX, 32'hFFFF_FFFF);
      send_op(CMD_DIV, Q_ONE, 32'h0000_0000);
      send_op(CMD_DIV, Q_MIN, 32'h0000_0000);
      send_op(CMD_DIV, 32'h0000_0000, 32'h0000_0000);
      send_op(CMD_DIV, Q_MIN, 32'hFFFF_FFFF);
      send_op(CMD_DIV, Q_ONE, 32'h0003_0000);
      send_op(CMD_DIV, 32'hFFFF_FFFF, 32'h0003_0000);
      send_op(CMD_DIV, Q_MAX, 32'h0000_0001);
      send_op(CMD_DIV, Q_MIN, Q_MAX);
      send_op(CMD_DIV, Q_MAX, Q_MIN);
      send_op(CMD_DIV, 32'hFFFF_0000, 32'hFFFF_0000);
      send_op(CMD_DIV, 32'h0005_0000, 32'hFFFE_0000);
   endtask

   task automatic test_random_ops(input int count, input int idle_pct, input int stall_pct);
      set_pace(idle_pct, stall_pct, 0);
      repeat (count)
         send_op(cmd_type'($urandom_range(3)), rand_operand(), rand_operand());
   endtask

   // output held off long enough for the pipeline to fill and stall the input
   task automatic test_output_hold_off(input int count);
      set_pace(0, 0, 300);
      repeat (count)
         send_op(cmd_type'($urandom_range(3)), rand_operand(), rand_operand());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_edge_operands();
      test_random_ops(300, 0, 0);
      test_random_ops(200, 87, 0);
      test_random_ops(200, 0, 87);
      test_random_ops(250, 9, 9);
      test_output_hold_off(150);
      set_pace(0, 0, 0);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_fixed_point_q16_alu_core OK");
      end else begin
         $display("tb_fixed_point_q16_alu_core NOT OK");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+sv
sv/fpq16_pkg.sv
sv/fpq16_front.sv
sv/fpq16_div_cell.sv
sv/fpq16_back.sv
sv/fixed_point_q16_alu_core.sv
sv/fpq16_checker.sv
sim/tb_fixed_point_q16_alu_core.sv
